### rtl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants for the sorted route table
// Route entry layout, request and result beats, opcodes, status codes,
// settings register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int ADDR_W        = 14;
  localparam int COST_W        = 12;
  localparam int STATUS_W      = 3;
  localparam int COUNT_OUT_W   = 7;
  localparam int DEPTH_DEFAULT = 64;
  localparam int CFG_IDX_W     = 2;

  localparam logic [ADDR_W-1:0] ADDR_RSV_LO = '0;
  localparam logic [ADDR_W-1:0] ADDR_RSV_HI = '1;
  localparam logic [COST_W-1:0] COST_RSV    = '1;

  // settings register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ADD_OVERWRITE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_BY_DEST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_BY_HOP  = 2'd2;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_FIND   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_RES_DEST  = 3'd1,
    ST_RES_HOP   = 3'd2,
    ST_RES_COST  = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_RESOLVE,
    S_SHUP_RD,
    S_SHUP_WR,
    S_SHDN_RD,
    S_SHDN_WR
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [COST_W-1:0] cost;
    logic [ADDR_W-1:0] hop;
  } route_entry_t;

  typedef struct packed {
    action_t           action;
    logic [ADDR_W-1:0] dest_address;
    logic [COST_W-1:0] route_cost;
    logic [ADDR_W-1:0] next_hop;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   hit;
    logic [COST_W-1:0]      found_cost;
    logic [ADDR_W-1:0]      found_next_hop;
  } out_item_t;

  typedef struct packed {
    logic add_overwrite;
    logic remove_by_destination;
    logic remove_by_next_hop;
  } cfg_t;

  typedef struct packed {
    logic eq;        // destination equals the key
    logic ge;        // destination is at or above the key
    logic rm_match;  // entry matches under the selected remove mode
  } cmp_res_t;

endpackage

### rtl/srt_table_mem.sv
// ----------------------------------------------------------------------------
// srt_table_mem: route entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srt_table_mem #(
  parameter int DEPTH = srt_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  srt_pkg::route_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output srt_pkg::route_entry_t rd_data
);
  import srt_pkg::*;

  route_entry_t mem [DEPTH];
  route_entry_t rd_data_r;

  // write entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read entry, data valid the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/srt_cmp_unit.sv
// ----------------------------------------------------------------------------
// srt_cmp_unit: shared entry compare unit
// Compares one stored entry against the request key for ordering, exact
// destination match and the configured remove match.
// ----------------------------------------------------------------------------
module srt_cmp_unit (
  input  srt_pkg::route_entry_t entry,
  input  srt_pkg::route_entry_t key,
  input  srt_pkg::cfg_t         mode,
  output srt_pkg::cmp_res_t     res
);
  import srt_pkg::*;

  logic dest_eq;
  logic cost_eq;
  logic hop_eq;

  assign dest_eq = (entry.dest == key.dest);
  assign cost_eq = (entry.cost == key.cost);
  assign hop_eq  = (entry.hop == key.hop);

  // order and match flags
  always_comb begin
    res.eq = dest_eq;
    res.ge = (entry.dest >= key.dest);
    priority if (mode.remove_by_destination && mode.remove_by_next_hop) begin
      res.rm_match = dest_eq && hop_eq;
    end else if (mode.remove_by_destination) begin
      res.rm_match = dest_eq;
    end else if (mode.remove_by_next_hop) begin
      res.rm_match = hop_eq;
    end else begin
      res.rm_match = dest_eq && cost_eq && hop_eq;
    end
  end

endmodule

### rtl/srt_ctrl.sv
// ----------------------------------------------------------------------------
// srt_ctrl: request sequencer for the sorted route table
// Walks the table through the compare unit, then shifts entries up for an
// insert or down for a removal, one entry per read and write state pair.
// ----------------------------------------------------------------------------
module srt_ctrl #(
  parameter int TABLE_DEPTH = srt_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  srt_pkg::in_item_t  in_item,
  input  srt_pkg::cfg_t      cfg,
  output logic               busy,
  output logic               out_valid,
  output srt_pkg::out_item_t out_item
);
  import srt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  state_t             state_r, state_nxt;
  in_item_t           req_r, req_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   sh_r, sh_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               found_r, found_nxt;
  logic [COST_W-1:0]  fcost_r, fcost_nxt;
  logic [ADDR_W-1:0]  fhop_r, fhop_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic               mem_wr_en;
  logic [IDX_W-1:0]   mem_wr_addr;
  route_entry_t       mem_wr_data;
  logic               mem_rd_en;
  logic [IDX_W-1:0]   mem_rd_addr;
  route_entry_t       mem_rd_data;

  route_entry_t       key;
  cmp_res_t           cmp;
  status_t            scr;
  logic               reject;
  logic               at_end;
  logic               is_full;
  logic               scan_stop;
  logic               sh_at_pos;
  logic               sh_last;
  logic [CNT_W-1:0]   sh_inc;
  logic [CNT_W-1:0]   sh_dec;

  // check reserved operand values in fixed order
  function automatic status_t screen(in_item_t it);
    status_t st;
    if (it.dest_address == ADDR_RSV_LO || it.dest_address == ADDR_RSV_HI) begin
      st = ST_RES_DEST;
    end else if (it.next_hop == ADDR_RSV_LO || it.next_hop == ADDR_RSV_HI) begin
      st = ST_RES_HOP;
    end else if (it.route_cost == COST_RSV) begin
      st = ST_RES_COST;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

  // pack one result beat
  function automatic out_item_t make_result(status_t st, logic [CNT_W-1:0] cnt,
                                            logic hit, logic [COST_W-1:0] c,
                                            logic [ADDR_W-1:0] h);
    out_item_t r;
    r.status         = st;
    r.entry_count    = COUNT_OUT_W'(cnt);
    r.hit            = hit;
    r.found_cost     = c;
    r.found_next_hop = h;
    return r;
  endfunction

  srt_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign key.dest = req_r.dest_address;
  assign key.cost = req_r.route_cost;
  assign key.hop  = req_r.next_hop;

  srt_cmp_unit u_cmp (
    .entry (mem_rd_data),
    .key   (key),
    .mode  (cfg),
    .res   (cmp)
  );

  // sequencer conditions
  assign scr       = screen(in_item);
  assign reject    = (in_item.action != ACT_FIND) && (scr != ST_OK);
  assign at_end    = (idx_r == cnt_r);
  assign is_full   = (cnt_r == CNT_FULL);
  assign scan_stop = (req_r.action == ACT_REMOVE) ? cmp.rm_match : cmp.ge;
  assign sh_inc    = sh_r + CNT_ONE;
  assign sh_dec    = sh_r - CNT_ONE;
  assign sh_at_pos = (sh_r == idx_r);
  assign sh_last   = (sh_inc == cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = reject ? S_IDLE : S_SCAN_RD;
        end
      end
      S_SCAN_RD:  state_nxt = at_end ? S_RESOLVE : S_SCAN_CMP;
      S_SCAN_CMP: state_nxt = scan_stop ? S_RESOLVE : S_SCAN_RD;
      S_RESOLVE: begin
        if (req_r.action == ACT_ADD && !found_r && !is_full) begin
          state_nxt = S_SHUP_RD;
        end else if (req_r.action == ACT_REMOVE && found_r) begin
          state_nxt = S_SHDN_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SHUP_RD:  state_nxt = sh_at_pos ? S_IDLE : S_SHUP_WR;
      S_SHUP_WR:  state_nxt = S_SHUP_RD;
      S_SHDN_RD:  state_nxt = sh_last ? S_IDLE : S_SHDN_WR;
      S_SHDN_WR:  state_nxt = S_SHDN_RD;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    fcost_nxt     = fcost_r;
    fhop_nxt      = fhop_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = idx_r[IDX_W-1:0];
    mem_wr_data   = key;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = idx_r[IDX_W-1:0];

    unique case (state_r)
      // take the request, answer reserved operands at once
      S_IDLE: begin
        if (start) begin
          req_nxt = in_item;
          idx_nxt = '0;
          if (reject) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = make_result(scr, cnt_r, 1'b0, '0, '0);
          end
        end
      end
      // fetch the next entry, or close the scan as a miss
      S_SCAN_RD: begin
        if (at_end) begin
          found_nxt = 1'b0;
        end else begin
          mem_rd_en = 1'b1;
        end
      end
      // compare and either stop or advance
      S_SCAN_CMP: begin
        if (scan_stop) begin
          found_nxt = (req_r.action == ACT_REMOVE) ? 1'b1 : cmp.eq;
          fcost_nxt = mem_rd_data.cost;
          fhop_nxt  = mem_rd_data.hop;
        end else begin
          idx_nxt = idx_r + CNT_ONE;
        end
      end
      // act on the scan outcome
      S_RESOLVE: begin
        unique case (req_r.action)
          ACT_FIND: begin
            out_valid_nxt = 1'b1;
            if (found_r) begin
              out_item_nxt = make_result(ST_OK, cnt_r, 1'b1, fcost_r, fhop_r);
            end else begin
              out_item_nxt = make_result(ST_NOT_FOUND, cnt_r, 1'b0, '0, '0);
            end
          end
          ACT_UPDATE: begin
            out_valid_nxt = 1'b1;
            if (found_r) begin
              mem_wr_en    = 1'b1;
              out_item_nxt = make_result(ST_OK, cnt_r, 1'b0, '0, '0);
            end else begin
              out_item_nxt = make_result(ST_NOT_FOUND, cnt_r, 1'b0, '0, '0);
            end
          end
          ACT_ADD: begin
            if (found_r) begin
              mem_wr_en     = cfg.add_overwrite;
              out_valid_nxt = 1'b1;
              out_item_nxt  = make_result(ST_OK, cnt_r, 1'b0, '0, '0);
            end else if (is_full) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = make_result(ST_FULL, cnt_r, 1'b0, '0, '0);
            end else begin
              sh_nxt = cnt_r;
            end
          end
          ACT_REMOVE: begin
            if (found_r) begin
              sh_nxt = idx_r;
            end else begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = make_result(ST_NOT_FOUND, cnt_r, 1'b0, '0, '0);
            end
          end
          default: begin
            out_valid_nxt = 1'b0;
          end
        endcase
      end
      // open a gap: read the entry below, or drop the new entry in place
      S_SHUP_RD: begin
        if (sh_at_pos) begin
          mem_wr_en     = 1'b1;
          mem_wr_addr   = sh_r[IDX_W-1:0];
          cnt_nxt       = cnt_r + CNT_ONE;
          out_valid_nxt = 1'b1;
          out_item_nxt  = make_result(ST_OK, cnt_r + CNT_ONE, 1'b0, '0, '0);
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = sh_dec[IDX_W-1:0];
        end
      end
      S_SHUP_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = sh_r[IDX_W-1:0];
        mem_wr_data = mem_rd_data;
        sh_nxt      = sh_dec;
      end
      // close the gap: read the entry above, or finish the removal
      S_SHDN_RD: begin
        if (sh_last) begin
          cnt_nxt       = cnt_r - CNT_ONE;
          out_valid_nxt = 1'b1;
          out_item_nxt  = make_result(ST_OK, cnt_r - CNT_ONE, 1'b0, '0, '0);
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = sh_inc[IDX_W-1:0];
        end
      end
      S_SHDN_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = sh_r[IDX_W-1:0];
        mem_wr_data = mem_rd_data;
        sh_nxt      = sh_inc;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    sh_r       <= sh_nxt;
    found_r    <= found_nxt;
    fcost_r    <= fcost_nxt;
    fhop_r     <= fhop_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### rtl/sorted_route_table_top.sv
// ----------------------------------------------------------------------------
// sorted_route_table_top: sorted routing table with add, remove, update, find
// A reserved operand is answered straight from idle; other requests read and
// compare entries in turn, then read and write each entry moved, before the
// result strobe. Busy holds until the strobe, and the next start is taken
// at the end of the strobe cycle. Reset clears the entry count and settings;
// table contents are kept. Results are one-cycle strobes; no receiver stall.
// ----------------------------------------------------------------------------
module sorted_route_table_top #(
  parameter int TABLE_DEPTH = srt_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  srt_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output srt_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic               cfg_data
);
  import srt_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // decode a settings write; unknown index is ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ADD_OVERWRITE:  cfg_nxt.add_overwrite         = cfg_data;
        CFG_REMOVE_BY_DEST: cfg_nxt.remove_by_destination = cfg_data;
        CFG_REMOVE_BY_HOP:  cfg_nxt.remove_by_next_hop    = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  // hold settings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  srt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### test/tb_sorted_route_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_route_table_top: self-checking bench for the sorted route table
// A directed table covers reserved operands, the address and cost extremes,
// an empty table and every request type. Random phases then sweep the three
// settings: a fill phase runs the table into the full status, mixed phases
// mostly pick destinations already held, and often held hops, so that remove,
// update and find hit, and a last phase drains the table. Each result beat is
// checked field by field against a directed row's value or a model of the table.
// ----------------------------------------------------------------------------
module tb_sorted_route_table_top;
  import srt_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 4 * DEPTH + 8;
  localparam int PHASE_ITEMS  = 140;
  localparam int NUM_PHASES   = 6;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  in_item_t   in_item;
  logic       busy;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic       cfg_data;

  // expectation override for directed rows, carried alongside the beat
  bit         want_typed;
  out_item_t  want_fixed;

  out_item_t  pending_results[$];
  int         fail_count = 0;
  int         cycle_count = 0;

  // model state: sorted entries, fill level and settings
  route_entry_t rt_entries[DEPTH];
  int           rt_count = 0;
  cfg_t         rt_cfg = '0;

  sorted_route_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // end the run once the cycle limit is reached
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int rt_locate(logic [ADDR_W-1:0] d);
    int k;
    for (k = 0; k < rt_count; k++)
      if (rt_entries[k].dest == d) return k;
    return rt_count;
  endfunction

  // apply one request to the model table and return its result beat
  function automatic out_item_t route_table_apply(in_item_t rq);
    out_item_t    res;
    route_entry_t ent;
    int           k;
    int           pos;
    bit           m;
    res = '0;
    res.status = ST_OK;
    ent.dest = rq.dest_address;
    ent.cost = rq.route_cost;
    ent.hop = rq.next_hop;
    if (rq.action == ACT_FIND) begin
      k = rt_locate(ent.dest);
      if (k < rt_count) begin
        res.hit = 1'b1;
        res.found_cost = rt_entries[k].cost;
        res.found_next_hop = rt_entries[k].hop;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end else if (ent.dest == ADDR_RSV_LO || ent.dest == ADDR_RSV_HI) begin
      res.status = ST_RES_DEST;
    end else if (ent.hop == ADDR_RSV_LO || ent.hop == ADDR_RSV_HI) begin
      res.status = ST_RES_HOP;
    end else if (ent.cost == COST_RSV) begin
      res.status = ST_RES_COST;
    end else begin
      case (rq.action)
        ACT_ADD: begin
          k = rt_locate(ent.dest);
          if (k < rt_count) begin
            if (rt_cfg.add_overwrite) rt_entries[k] = ent;
          end else if (rt_count >= DEPTH) begin
            res.status = ST_FULL;
          end else begin
            // open a slot at the sorted position
            pos = 0;
            while (pos < rt_count && rt_entries[pos].dest < ent.dest) pos++;
            for (k = rt_count; k > pos; k--) rt_entries[k] = rt_entries[k-1];
            rt_entries[pos] = ent;
            rt_count++;
          end
        end
        ACT_REMOVE: begin
          for (k = 0; k < rt_count; k++) begin
            if (rt_cfg.remove_by_destination && rt_cfg.remove_by_next_hop)
              m = rt_entries[k].dest == ent.dest && rt_entries[k].hop == ent.hop;
            else if (rt_cfg.remove_by_destination)
              m = rt_entries[k].dest == ent.dest;
            else if (rt_cfg.remove_by_next_hop)
              m = rt_entries[k].hop == ent.hop;
            else
              m = rt_entries[k] == ent;
            if (m) break;
          end
          if (k >= rt_count) begin
            res.status = ST_NOT_FOUND;
          end else begin
            // close the gap
            for (; k + 1 < rt_count; k++) rt_entries[k] = rt_entries[k+1];
            rt_count--;
          end
        end
        default: begin
          k = rt_locate(ent.dest);
          if (k < rt_count) rt_entries[k] = ent;
          else res.status = ST_NOT_FOUND;
        end
      endcase
    end
    res.entry_count = rt_count[COUNT_OUT_W-1:0];
    return res;
  endfunction

  // random request, biased toward entries already in the table
  function automatic in_item_t draw_request(int add_pct);
    in_item_t     rq;
    route_entry_t e;
    int           sel;
    e = '0;
    if (rt_count > 0) e = rt_entries[$urandom_range(0, rt_count - 1)];
    sel = $urandom_range(0, 99);
    if (sel < add_pct) begin
      rq.action = ACT_ADD;
    end else begin
      sel = $urandom_range(0, 9);
      if (sel < 4) rq.action = ACT_REMOVE;
      else if (sel < 6) rq.action = ACT_UPDATE;
      else rq.action = ACT_FIND;
    end
    sel = $urandom_range(0, 99);
    if (sel < 5)
      rq.dest_address = $urandom_range(0, 1) ? ADDR_RSV_HI : ADDR_RSV_LO;
    else if (rt_count > 0 && sel < ((rq.action == ACT_ADD) ? 20 : 65))
      rq.dest_address = e.dest;
    else
      rq.dest_address = ADDR_W'($urandom_range(1, 16382));
    sel = $urandom_range(0, 99);
    if (sel < 4) rq.route_cost = COST_RSV;
    else if (rt_count > 0 && sel < 50) rq.route_cost = e.cost;
    else rq.route_cost = COST_W'($urandom_range(0, 4094));
    sel = $urandom_range(0, 99);
    if (sel < 5) rq.next_hop = $urandom_range(0, 1) ? ADDR_RSV_HI : ADDR_RSV_LO;
    else if (rt_count > 0 && sel < 45) rq.next_hop = e.hop;
    else if (sel < 70) rq.next_hop = ADDR_W'($urandom_range(1, 8));
    else rq.next_hop = ADDR_W'($urandom_range(1, 16382));
    return rq;
  endfunction

  function automatic dir_row_t dir_row(action_t a, int d, int c, int h, bit typed,
                                       status_t st, int cnt, bit hit, int fc, int fh);
    dir_row_t r;
    r.item.action = a;
    r.item.dest_address = ADDR_W'(d);
    r.item.route_cost = COST_W'(c);
    r.item.next_hop = ADDR_W'(h);
    r.typed = typed;
    r.want.status = st;
    r.want.entry_count = COUNT_OUT_W'(cnt);
    r.want.hit = hit;
    r.want.found_cost = COST_W'(fc);
    r.want.found_next_hop = ADDR_W'(fh);
    return r;
  endfunction

  // idle stretches alternate with back-to-back runs
  function automatic int pick_gap(int n);
    return ((n % 60) < 15) ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send_request(in_item_t rq, bit typed, out_item_t want, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= rq;
    want_typed <= typed;
    want_fixed <= want;
    do @(posedge clk); while (busy);
  endtask

  // write all settings once the block has answered everything
  task automatic set_config(cfg_t c);
    logic [1:0] idx[3];
    logic       val[3];
    int         k;
    idx = '{CFG_ADD_OVERWRITE, CFG_REMOVE_BY_DEST, CFG_REMOVE_BY_HOP};
    val = '{c.add_overwrite, c.remove_by_destination, c.remove_by_next_hop};
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    for (k = 0; k < 3; k++) begin
      cfg_index <= idx[k];
      cfg_data <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // track settings, predict accepted requests, check result beats
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result beat: status=%0d count=%0d hit=%0d cost=%h hop=%h",
                     out_item.status, out_item.entry_count, out_item.hit,
                     out_item.found_cost, out_item.found_next_hop);
        end else begin
          want = pending_results.pop_front();
          if (out_item.status !== want.status || out_item.entry_count !== want.entry_count ||
              out_item.hit !== want.hit || out_item.found_cost !== want.found_cost ||
              out_item.found_next_hop !== want.found_next_hop) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display({"mismatch: expected status=%0d count=%0d hit=%0d cost=%h hop=%h,",
                        " got status=%0d count=%0d hit=%0d cost=%h hop=%h"},
                       want.status, want.entry_count, want.hit, want.found_cost,
                       want.found_next_hop, out_item.status, out_item.entry_count,
                       out_item.hit, out_item.found_cost, out_item.found_next_hop);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ADD_OVERWRITE:  rt_cfg.add_overwrite = cfg_data;
          CFG_REMOVE_BY_DEST: rt_cfg.remove_by_destination = cfg_data;
          CFG_REMOVE_BY_HOP:  rt_cfg.remove_by_next_hop = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        want = route_table_apply(in_item);
        if (want_typed) want = want_fixed;
        pending_results.push_back(want);
      end
    end
  end

  initial begin : stimulus
    dir_row_t rows[$];
    cfg_t     phase_cfg[NUM_PHASES];
    int       add_pct[NUM_PHASES];
    int       n;
    int       ph;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ADD_OVERWRITE;
    cfg_data = 1'b0;
    want_typed = 1'b0;
    want_fixed = '0;
    phase_cfg = '{3'b100, 3'b010, 3'b001, 3'b111, 3'b000, 3'b010};
    add_pct = '{85, 30, 30, 30, 30, 10};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, reserved operands in check order
    rows.push_back(dir_row(ACT_FIND, 'h1234, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 0));
    rows.push_back(dir_row(ACT_ADD, 'h0000, 5, 7, 1, ST_RES_DEST, 0, 0, 0, 0));
    rows.push_back(dir_row(ACT_ADD, 'h3fff, 5, 7, 1, ST_RES_DEST, 0, 0, 0, 0));
    rows.push_back(dir_row(ACT_ADD, 5, 5, 'h0000, 1, ST_RES_HOP, 0, 0, 0, 0));
    rows.push_back(dir_row(ACT_ADD, 5, 5, 'h3fff, 1, ST_RES_HOP, 0, 0, 0, 0));
    rows.push_back(dir_row(ACT_ADD, 5, 'hfff, 7, 1, ST_RES_COST, 0, 0, 0, 0));
    rows.push_back(dir_row(ACT_REMOVE, 0, 'hfff, 0, 1, ST_RES_DEST, 0, 0, 0, 0));
    rows.push_back(dir_row(ACT_UPDATE, 5, 'hfff, 0, 1, ST_RES_HOP, 0, 0, 0, 0));
    rows.push_back(dir_row(ACT_UPDATE, 5, 'hfff, 7, 1, ST_RES_COST, 0, 0, 0, 0));
    rows.push_back(dir_row(ACT_UPDATE, 5, 1, 7, 1, ST_NOT_FOUND, 0, 0, 0, 0));
    rows.push_back(dir_row(ACT_REMOVE, 5, 1, 7, 1, ST_NOT_FOUND, 0, 0, 0, 0));
    // legal extremes, inserted out of order
    rows.push_back(dir_row(ACT_ADD, 1, 0, 1, 1, ST_OK, 1, 0, 0, 0));
    rows.push_back(dir_row(ACT_ADD, 'h3ffe, 'hffe, 'h3ffe, 1, ST_OK, 2, 0, 0, 0));
    rows.push_back(dir_row(ACT_ADD, 'h2000, 'h0aa, 'h1555, 1, ST_OK, 3, 0, 0, 0));
    rows.push_back(dir_row(ACT_FIND, 'h3ffe, 0, 0, 1, ST_OK, 3, 1, 'hffe, 'h3ffe));
    rows.push_back(dir_row(ACT_FIND, 1, 'hfff, 'h3fff, 1, ST_OK, 3, 1, 0, 1));
    rows.push_back(dir_row(ACT_FIND, 0, 0, 0, 1, ST_NOT_FOUND, 3, 0, 0, 0));
    rows.push_back(dir_row(ACT_FIND, 'h3fff, 'hfff, 'h3fff, 1, ST_NOT_FOUND, 3, 0, 0, 0));
    // existing destination, update, whole-entry remove miss and hit
    rows.push_back(dir_row(ACT_ADD, 'h2000, 5, 6, 0, ST_OK, 0, 0, 0, 0));
    rows.push_back(dir_row(ACT_UPDATE, 'h2000, 'h123, 'h2aaa, 0, ST_OK, 0, 0, 0, 0));
    rows.push_back(dir_row(ACT_FIND, 'h2000, 0, 0, 0, ST_OK, 0, 0, 0, 0));
    rows.push_back(dir_row(ACT_REMOVE, 'h2000, 'h124, 'h2aaa, 0, ST_OK, 0, 0, 0, 0));
    rows.push_back(dir_row(ACT_REMOVE, 'h2000, 'h123, 'h2aaa, 0, ST_OK, 0, 0, 0, 0));
    rows.push_back(dir_row(ACT_FIND, 'h2000, 0, 0, 0, ST_OK, 0, 0, 0, 0));

    foreach (rows[n]) send_request(rows[n].item, rows[n].typed, rows[n].want, pick_gap(n));

    // random phases, one setting each
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      set_config(phase_cfg[ph]);
      for (n = 0; n < PHASE_ITEMS; n++)
        send_request(draw_request(add_pct[ph]), 1'b0, '0, pick_gap(n));
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
